### rtl/core/tdcf_pkg.sv
`default_nettype none

package tdcf_pkg;

    // block geometry and register map
    localparam int          BLOCK_WORDS   = 64;
    localparam logic [5:0]  NO_CHAN       = 6'h3F;
    localparam logic [9:0]  WINDOW_RESET  = 10'd100;
    localparam int          PADDR_W       = 3;
    localparam logic [0:0]  REG_REPEAT_WINDOW = 1'b0;

    // word kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_DIRECT = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // one input item
    typedef struct packed {
        mode_t       mode;
        logic [15:0] word;
        logic [15:0] next_word;
        logic [5:0]  word_index;
        logic        responded;
    } item_t;

    // one result item
    typedef struct packed {
        logic        accepted;
        logic [4:0]  channel;
        logic [16:0] time_count;
        logic        edge_record;
        logic        edge_mode;
        logic [1:0]  resolution_shift;
        logic        single_word;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/tdcf_cfg.sv
`default_nettype none

module tdcf_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tdcf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output logic      [9:0]                    repeat_window
);

    logic [9:0] window_reg;
    logic       sel_window;

    // word address decode, byte offset ignored
    assign sel_window = (paddr[tdcf_pkg::PADDR_W-1:2] == tdcf_pkg::REG_REPEAT_WINDOW);
    assign pready     = 1'b1;

    // register write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= tdcf_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_window)
        begin
            window_reg <= pwdata[9:0];
        end
    end

    // read back
    assign prdata        = sel_window ? {22'd0, window_reg} : 32'd0;
    assign repeat_window = window_reg;

endmodule

`default_nettype wire

### rtl/core/tdcf_filter.sv
`default_nettype none

module tdcf_filter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire tdcf_pkg::item_t   item,
    input  wire logic [9:0]        repeat_window,
    output logic                   res_valid,
    output tdcf_pkg::result_t      result
);

    // header and history state
    logic        edge_mode_reg, edge_mode_next;
    logic [1:0]  shift_reg, shift_next;
    logic        single_reg, single_next;
    logic [5:0]  last_chan_reg, last_chan_next;
    logic [5:0]  prior_chan_reg, prior_chan_next;
    logic [9:0]  last_time_reg, last_time_next;
    logic        pending_reg, pending_next;
    logic [15:0] pair_time_reg, pair_time_next;
    logic [4:0]  pair_chan_reg, pair_chan_next;

    // word fields
    logic [4:0]  ch;
    logic [9:0]  t;
    logic        er;
    logic        last_slot;
    logic        has_last;
    logic        same_chan;
    logic [9:0]  time_gap;
    logic        block_abort;
    logic [15:0] part;

    function automatic logic [15:0] pair_part(input logic [15:0] w);
        pair_part = w[8] ? {w[7:0], 8'h00} : {8'h00, w[7:0]};
    endfunction

    assign ch        = item.word[14:10];
    assign er        = item.word[9];
    assign t         = edge_mode_reg ? {1'b0, item.word[8:0]} : item.word[9:0];
    assign last_slot = (32'(item.word_index) == 32'(tdcf_pkg::BLOCK_WORDS - 1));
    assign has_last  = (last_chan_reg != tdcf_pkg::NO_CHAN);
    assign same_chan = has_last && (ch == last_chan_reg[4:0]);
    assign time_gap  = (t > last_time_reg) ? (t - last_time_reg) : (last_time_reg - t);
    assign part      = pair_part(item.word);

    // block end checks
    assign block_abort = ((item.word == 16'd0) && !last_slot && (item.next_word == 16'd0))
                      || (has_last && (ch < last_chan_reg[4:0]))
                      || (same_chan && ((last_chan_reg == prior_chan_reg)
                                        || (time_gap < repeat_window)));

    // decode and next state
    always_comb
    begin
        edge_mode_next  = edge_mode_reg;
        shift_next      = shift_reg;
        single_next     = single_reg;
        last_chan_next  = last_chan_reg;
        prior_chan_next = prior_chan_reg;
        last_time_next  = last_time_reg;
        pending_next    = pending_reg;
        pair_time_next  = pair_time_reg;
        pair_chan_next  = pair_chan_reg;
        res_valid          = 1'b0;
        result.accepted    = 1'b0;
        result.channel     = 5'd0;
        result.time_count  = 17'd0;
        result.edge_record = 1'b0;

        unique case (item.mode)
            tdcf_pkg::MODE_HEADER:
            begin
                pending_next    = 1'b0;
                edge_mode_next  = item.word[10];
                shift_next      = item.word[9:8];
                single_next     = !item.word[14];
                res_valid       = 1'b1;
                result.accepted = item.word[15];
            end
            tdcf_pkg::MODE_BLOCK:
            begin
                pending_next = 1'b0;
                res_valid    = 1'b1;
                if (block_abort)
                begin
                    last_chan_next  = tdcf_pkg::NO_CHAN;
                    prior_chan_next = tdcf_pkg::NO_CHAN;
                end
                else if (last_slot)
                begin
                    // history takes the word, then the block closes
                    last_time_next  = t;
                    last_chan_next  = tdcf_pkg::NO_CHAN;
                    prior_chan_next = tdcf_pkg::NO_CHAN;
                end
                else
                begin
                    last_time_next     = t;
                    prior_chan_next    = last_chan_reg;
                    last_chan_next     = {1'b0, ch};
                    result.accepted    = 1'b1;
                    result.channel     = ch;
                    result.time_count  = {7'd0, t};
                    result.edge_record = er;
                end
            end
            tdcf_pkg::MODE_DIRECT:
            begin
                if (pending_reg)
                begin
                    // second word of a pair
                    pending_next = 1'b0;
                    res_valid    = 1'b1;
                    if (!item.word[15])
                    begin
                        result.accepted    = 1'b1;
                        result.channel     = pair_chan_reg;
                        result.time_count  = {1'b0, pair_time_reg} + {1'b0, part};
                        result.edge_record = er;
                    end
                end
                else if (!item.responded || item.word[15])
                begin
                    res_valid = 1'b1;
                end
                else if (single_reg)
                begin
                    res_valid          = 1'b1;
                    result.accepted    = 1'b1;
                    result.channel     = ch;
                    result.time_count  = {7'd0, t};
                    result.edge_record = er;
                end
                else
                begin
                    // first word of a pair, held for the next item
                    pending_next   = 1'b1;
                    pair_time_next = part;
                    pair_chan_next = ch;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        result.edge_mode        = edge_mode_next;
        result.resolution_shift = shift_next;
        result.single_word      = single_next;
    end

    // state update once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_mode_reg  <= 1'b0;
            shift_reg      <= 2'd0;
            single_reg     <= 1'b1;
            last_chan_reg  <= tdcf_pkg::NO_CHAN;
            prior_chan_reg <= tdcf_pkg::NO_CHAN;
            last_time_reg  <= 10'd0;
            pending_reg    <= 1'b0;
            pair_time_reg  <= 16'd0;
            pair_chan_reg  <= 5'd0;
        end
        else if (advance)
        begin
            edge_mode_reg  <= edge_mode_next;
            shift_reg      <= shift_next;
            single_reg     <= single_next;
            last_chan_reg  <= last_chan_next;
            prior_chan_reg <= prior_chan_next;
            last_time_reg  <= last_time_next;
            pending_reg    <= pending_next;
            pair_time_reg  <= pair_time_next;
            pair_chan_reg  <= pair_chan_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tdc_readout_word_filter_top.sv
// the input register takes the item, the decode stage works on it, and the result
// register then loads its result item, which is offered from there
// throughput: one item per cycle unless m_tready stalls a full result register, set by
// the single decode stage between the input register and the result register that updates the history
// reset: rst_n is asynchronous, active low; it empties both registers, loads the
// header state (edge mode 0, shift 0, single word), clears history and pairs
`default_nettype none

module tdc_readout_word_filter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // word[15:0], next_word[31:16], word_index[37:32], responded[38], ignored[39]
    input  wire logic [39:0]                   s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // accepted[0], channel[5:1], time_count[22:6], edge_record[23],
    // edge_mode[24], resolution_shift[26:25], single_word[27], zero[31:28]
    output logic      [31:0]                   m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tdcf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    logic              in_valid_reg;
    tdcf_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    tdcf_pkg::result_t out_result_reg;
    logic              advance;
    logic              res_valid;
    tdcf_pkg::result_t result;
    logic [9:0]        repeat_window;

    // configuration register
    tdcf_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .repeat_window (repeat_window)
    );

    // pipeline moves when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.mode       <= tdcf_pkg::mode_t'(s_tuser);
            in_item_reg.word       <= s_tdata[15:0];
            in_item_reg.next_word  <= s_tdata[31:16];
            in_item_reg.word_index <= s_tdata[37:32];
            in_item_reg.responded  <= s_tdata[38];
        end
    end

    // decode and history
    tdcf_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (in_item_reg),
        .repeat_window (repeat_window),
        .res_valid     (res_valid),
        .result        (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.single_word,
                       out_result_reg.resolution_shift,
                       out_result_reg.edge_mode,
                       out_result_reg.edge_record,
                       out_result_reg.time_count,
                       out_result_reg.channel,
                       out_result_reg.accepted};

endmodule

`default_nettype wire

### rtl/core/tdcf_checker.sv
`default_nettype none

module tdcf_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [31:0]                   m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side never stalls while the result side is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // a rejected word carries no channel, time or edge
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[23:1] == 23'd0)
        else $error("rejected item carries data");

    // pair sums stay within two shifted bytes and the padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[22:6] <= 17'd130560 && m_tdata[31:28] == 4'd0)
        else $error("time out of range or padding set");

endmodule

bind tdc_readout_word_filter_top tdcf_checker u_tdcf_checker (.*);

`default_nettype wire
